// File: src/anb_pkg.sv
// Types and constants shared by the Annex B NAL scanner.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package anb_pkg;

  localparam logic [4:0] NAL_TYPE_MASK = 5'h1F;
  localparam logic [4:0] NAL_TYPE_IDR  = 5'd5;
  localparam logic [4:0] NAL_TYPE_SPS  = 5'd7;
  localparam logic [4:0] NAL_TYPE_PPS  = 5'd8;

  localparam logic [7:0] START_CODE_ONE = 8'h01;

  // unit phase codes; code 3 behaves as SEARCH
  localparam logic [1:0] PHASE_SEARCH = 2'd0;
  localparam logic [1:0] PHASE_HEADER = 2'd1;
  localparam logic [1:0] PHASE_BODY   = 2'd2;

  localparam logic [1:0] HELD_MAX = 2'd3;

  localparam logic RESULT_BYTE    = 1'b0;
  localparam logic RESULT_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_end;
  } in_word_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] out_byte;
    logic       keyframe;
    logic       run_last;
  } out_word_t;

  typedef struct packed {
    logic [1:0] held;      // zero bytes held back, 0..3
    logic [1:0] phase;
    logic       long_sc;   // pending start code is four bytes
    logic       fwd;       // current unit is SPS or PPS
    logic       idr;       // IDR header seen in this packet
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{held: 2'd0, phase: PHASE_SEARCH,
                                         long_sc: 1'b0, fwd: 1'b0, idr: 1'b0};

  // Result run of one input word: nz zeros, then 01, then data, then summary.
  typedef struct packed {
    logic [2:0] nz;
    logic       one;
    logic       byt;
    logic       sum;
    logic       key;
    logic [7:0] data;
  } run_desc_t;

endpackage
`default_nettype wire

// File: src/anb_step.sv
// Per-word scanner step: next scan state and the run of results it causes.
// Depends on anb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module anb_step import anb_pkg::*; (
  input  wire in_word_t    word,
  input  wire scan_state_t st,
  output scan_state_t      st_nxt,
  output run_desc_t        run
);

  logic [4:0]  nal_type;
  logic        body_fwd;
  scan_state_t mid;
  logic [2:0]  nz_mid;

  always_comb begin
    nal_type = word.data_byte[4:0] & NAL_TYPE_MASK;
    body_fwd = (st.phase == PHASE_BODY) && st.fwd;
    mid      = st;
    nz_mid   = 3'd0;
    run      = '0;
    run.data = word.data_byte;

    if (st.phase == PHASE_HEADER) begin
      mid.idr   = st.idr | (nal_type == NAL_TYPE_IDR);
      mid.fwd   = (nal_type == NAL_TYPE_SPS) || (nal_type == NAL_TYPE_PPS);
      mid.phase = PHASE_BODY;
      mid.held  = 2'd0;
      if (mid.fwd) begin
        nz_mid  = st.long_sc ? 3'd3 : 3'd2;
        run.one = 1'b1;
        run.byt = 1'b1;
      end
    end else if (word.data_byte == 8'h00) begin
      if (st.held != HELD_MAX) begin
        mid.held = st.held + 2'd1;
      end else if (body_fwd) begin
        // fourth zero pushes the oldest held one into the unit
        nz_mid = 3'd1;
      end
    end else if (word.data_byte == START_CODE_ONE && st.held >= 2'd2) begin
      mid.long_sc = (st.held == HELD_MAX);
      mid.held    = 2'd0;
      mid.phase   = PHASE_HEADER;
    end else begin
      if (body_fwd) begin
        nz_mid  = {1'b0, st.held};
        run.byt = 1'b1;
      end
      mid.held = 2'd0;
    end

    run.nz = nz_mid;
    st_nxt = mid;
    if (word.packet_end) begin
      // unit runs to packet end: flush held zeros
      if (mid.phase == PHASE_BODY && mid.fwd) begin
        run.nz = nz_mid + {1'b0, mid.held};
      end
      run.sum = 1'b1;
      run.key = mid.idr;
      st_nxt  = SCAN_RESET;
    end
  end

endmodule
`default_nettype wire

// File: src/annexb_nal_scanner_core.sv
// Annex B NAL scanner top: scan state, two-entry run queue, result stream.
// Depends on anb_pkg and anb_step.
// Throughput: one input word per cycle while queue slot 1 is free; a word causing
// n results (0..6) emits them one at a time, the output port being the limit.
// Latency: first result of a word is valid the cycle after it is accepted when no earlier run waits.
// Reset: rst_n synchronous active low clears scan state and the run queue.
`timescale 1ns / 1ps
`default_nettype none
module annexb_nal_scanner_core import anb_pkg::*; (
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_valid,
  output logic      in_ready,
  input  wire in_word_t in_data,
  output logic      out_valid,
  input  wire       out_ready,
  output out_word_t out_data
);

  scan_state_t st_r, st_nxt;
  run_desc_t   run_new;
  run_desc_t   q_r   [2];
  run_desc_t   q_nxt [2];
  logic [1:0]  qv_r, qv_nxt;
  run_desc_t   head, head_adv;
  logic [2:0]  head_cnt;
  logic        head_last, in_acc, out_acc, pop, push;

  anb_step u_step (
    .word   (in_data),
    .st     (st_r),
    .st_nxt (st_nxt),
    .run    (run_new)
  );

  assign in_ready = ~qv_r[1];
  assign in_acc   = in_valid & in_ready;
  assign push     = in_acc & ((run_new.nz != 3'd0) | run_new.one | run_new.byt | run_new.sum);

  assign head      = q_r[0];
  assign head_cnt  = head.nz + {2'b00, head.one} + {2'b00, head.byt} + {2'b00, head.sum};
  assign head_last = (head_cnt == 3'd1);
  assign out_valid = qv_r[0];
  assign out_acc   = out_valid & out_ready;
  assign pop       = out_acc & head_last;

  always_comb begin
    out_data          = '0;
    out_data.run_last = head_last;
    if (head.nz != 3'd0) begin
      out_data.result_kind = RESULT_BYTE;
    end else if (head.one) begin
      out_data.out_byte = START_CODE_ONE;
    end else if (head.byt) begin
      out_data.out_byte = head.data;
    end else begin
      out_data.result_kind = RESULT_SUMMARY;
      out_data.keyframe    = head.key;
    end
  end

  // consume the front element of the head run
  always_comb begin
    head_adv = head;
    priority if (head.nz != 3'd0) head_adv.nz  = head.nz - 3'd1;
    else if (head.one)            head_adv.one = 1'b0;
    else                          head_adv.byt = 1'b0;
  end

  always_comb begin
    q_nxt  = q_r;
    qv_nxt = qv_r;
    if (pop) begin
      q_nxt[0]  = q_r[1];
      qv_nxt    = {1'b0, qv_r[1]};
    end else if (out_acc) begin
      q_nxt[0]  = head_adv;
    end
    if (push) begin
      // push only when slot 1 is free, so after a pop slot 0 is free
      if (pop || !qv_r[0]) begin
        q_nxt[0]  = run_new;
        qv_nxt[0] = 1'b1;
      end else begin
        q_nxt[1]  = run_new;
        qv_nxt[1] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SCAN_RESET;
      qv_r <= 2'b00;
    end else begin
      if (in_acc) st_r <= st_nxt;
      qv_r <= qv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    qv_r[1] |-> qv_r[0])
    else $error("run queue slot 1 filled while slot 0 empty");

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.result_kind == RESULT_SUMMARY) |-> out_data.run_last)
    else $error("summary word not last of its run");

  a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.result_kind == RESULT_SUMMARY) |-> (out_data.out_byte == 8'h00))
    else $error("summary word carries data");

  a_packet_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.packet_end) |=> (st_r == SCAN_RESET))
    else $error("scan state not cleared after packet end");

  a_end_gives_summary: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.packet_end) |-> push)
    else $error("packet end produced no summary run");

endmodule
`default_nettype wire
